// File: rtl/tapc_pkg.sv
// Shared types, widths, register map and step schedule for the three-axis PID block.
// No dependencies; every other file of the block imports it.
package tapc_pkg;

  localparam int unsigned AxesDefault = 3;
  localparam int unsigned FieldW      = 32;
  localparam int unsigned ErrW        = 33;
  localparam int unsigned SumW        = 34;
  localparam int unsigned IntegW      = 48;
  localparam int unsigned OpW         = 48;
  localparam int unsigned DigitW      = 16;
  localparam int unsigned ProdW       = DigitW + 1 + FieldW + 1;
  localparam int unsigned AreaW       = 67;
  localparam int unsigned AccW        = 82;
  localparam int unsigned StepW       = 4;
  localparam int unsigned AddrW       = 5;
  localparam int unsigned DataW       = 32;

  localparam logic [31:0] GainPReset      = 32'd335544;
  localparam logic [31:0] GainIReset      = 32'd0;
  localparam logic [31:0] GainDReset      = 32'd80531;
  localparam logic [31:0] HalfPeriodReset = 32'd4294967;
  localparam logic        EnableReset     = 1'b1;

  localparam logic [2:0] RegGainP      = 3'd0;
  localparam logic [2:0] RegGainI      = 3'd1;
  localparam logic [2:0] RegGainD      = 3'd2;
  localparam logic [2:0] RegHalfPeriod = 3'd3;
  localparam logic [2:0] RegEnable     = 3'd4;

  // per-item schedule, three 16-bit digits per product
  localparam logic [StepW-1:0] StepPrep     = 4'd0;
  localparam logic [StepW-1:0] StepArea     = 4'd1;
  localparam logic [StepW-1:0] StepErr      = 4'd4;
  localparam logic [StepW-1:0] StepIntegUpd = 4'd5;
  localparam logic [StepW-1:0] StepDiff     = 4'd7;
  localparam logic [StepW-1:0] StepInteg    = 4'd10;
  localparam logic [StepW-1:0] StepMulEnd   = 4'd13;
  localparam logic [StepW-1:0] StepLast     = 4'd14;

  typedef enum logic [1:0] {
    TagNone  = 2'd0,
    TagArea  = 2'd1,
    TagDrive = 2'd2
  } tag_e;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StHold = 3'b100
  } state_e;

  typedef struct packed {
    logic             start;
    logic             active;
    logic [StepW-1:0] step;
  } ctrl_t;

  typedef struct packed {
    logic [FieldW-1:0] gain_p;
    logic [FieldW-1:0] gain_i;
    logic [FieldW-1:0] gain_d;
    logic [FieldW-1:0] half_period;
  } cfg_t;

endpackage

// File: rtl/three_axis_pid_controller.sv
// Top level of the three-axis PID block: configuration registers, one lane per axis.
// Depends on tapc_pkg, tapc_seq, tapc_lane and tapc_merge.
//
// One input beat is one control tick carrying a target and a measured value per axis;
// one output beat carries the saturated Q16.16 drive of every axis. All axes run in
// parallel lanes, each with a single 17x33 multiplier that works through twelve
// 16-bit partial products per tick (area, then P, D and I terms), so a result lands
// in the output register once all steps are done, or later if the output register is
// still full, and the next tick can be taken the cycle after that.
// The output register lets a new tick start while the previous result waits.
// Configuration is to be written through APB only while no tick is in flight; the block does not enforce it.
module three_axis_pid_controller
  import tapc_pkg::*;
#(
  parameter int unsigned AXES = AxesDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // target_x.. per axis, then measured_x.. per axis, 32 bits each from bit 0 up
  input  logic [2*AXES*FieldW-1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // drive_x.. per axis, 32 bits each from bit 0 up
  output logic [AXES*FieldW-1:0]   m_axis_tdata,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [AddrW-1:0]         paddr,
  input  logic [DataW-1:0]         pwdata,
  output logic [DataW-1:0]         prdata,
  output logic                     pready
);

  logic [FieldW-1:0]           gain_p_q;
  logic [FieldW-1:0]           gain_i_q;
  logic [FieldW-1:0]           gain_d_q;
  logic [FieldW-1:0]           half_period_q;
  logic                        enable_q;
  logic                        cfg_write;
  logic [2:0]                  reg_idx;
  cfg_t                        cfg;
  ctrl_t                       ctrl;
  logic                        load;
  logic                        out_free;
  logic [AXES-1:0][FieldW-1:0] lane_drive;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[AddrW-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q      <= GainPReset;
      gain_i_q      <= GainIReset;
      gain_d_q      <= GainDReset;
      half_period_q <= HalfPeriodReset;
      enable_q      <= EnableReset;
    end else if (cfg_write) begin
      unique case (reg_idx)
        RegGainP:      gain_p_q      <= pwdata;
        RegGainI:      gain_i_q      <= pwdata;
        RegGainD:      gain_d_q      <= pwdata;
        RegHalfPeriod: half_period_q <= pwdata;
        RegEnable:     enable_q      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegGainP:      prdata = gain_p_q;
      RegGainI:      prdata = gain_i_q;
      RegGainD:      prdata = gain_d_q;
      RegHalfPeriod: prdata = half_period_q;
      RegEnable:     prdata = {{(DataW-1){1'b0}}, enable_q};
      default:       prdata = '0;
    endcase
  end

  assign cfg.gain_p      = gain_p_q;
  assign cfg.gain_i      = gain_i_q;
  assign cfg.gain_d      = gain_d_q;
  assign cfg.half_period = half_period_q;

  tapc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .out_free_i (out_free),
    .s_ready_o  (s_axis_tready),
    .load_o     (load),
    .ctrl_o     (ctrl)
  );

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    tapc_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .cfg_i      (cfg),
      .target_i   ($signed(s_axis_tdata[g*FieldW +: FieldW])),
      .measured_i ($signed(s_axis_tdata[(AXES+g)*FieldW +: FieldW])),
      .drive_o    (lane_drive[g])
    );
  end

  tapc_merge #(
    .Axes (AXES)
  ) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .enable_i  (enable_q),
    .drive_i   (lane_drive),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_data_o  (m_axis_tdata),
    .free_o    (out_free)
  );

  a_load_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over an untaken beat");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a tick is in flight");

  a_disabled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !enable_q) |=> (m_axis_tvalid && m_axis_tdata == '0))
    else $error("drive not zero with enable off");

endmodule

// File: rtl/tapc_seq.sv
// Tick sequencer: input handshake, step counter shared by all lanes, result hand-off.
// Depends on tapc_pkg.
module tapc_seq
  import tapc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_valid_i,
  input  logic  out_free_i,
  output logic  s_ready_o,
  output logic  load_o,
  output ctrl_t ctrl_o
);

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             start;

  assign s_ready_o = (state_q == StIdle);
  assign start     = s_valid_i && s_ready_o;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    load_o  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          state_d = StRun;
          step_d  = StepPrep;
        end
      end
      StRun: begin
        if (step_q == StepLast) begin
          if (out_free_i) begin
            load_o  = 1'b1;
            state_d = StIdle;
          end else begin
            state_d = StHold;
          end
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      StHold: begin
        if (out_free_i) begin
          load_o  = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= StepPrep;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign ctrl_o.start  = start;
  assign ctrl_o.active = (state_q == StRun);
  assign ctrl_o.step   = step_q;

endmodule

// File: rtl/tapc_lane.sv
// One axis: error, trapezoidal integrator and PID sum on a 17x33 multiplier
// stepped over 16-bit digits. Depends on tapc_pkg.
module tapc_lane
  import tapc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctrl_t                    ctrl_i,
  input  cfg_t                     cfg_i,
  input  logic signed [FieldW-1:0] target_i,
  input  logic signed [FieldW-1:0] measured_i,
  output logic signed [FieldW-1:0] drive_o
);

  logic signed [ErrW-1:0]   err_q;
  logic signed [ErrW-1:0]   last_err_q;
  logic signed [SumW-1:0]   sum_q;
  logic signed [SumW-1:0]   diff_q;
  logic signed [IntegW-1:0] integ_q, integ_d;
  logic signed [ProdW-1:0]  prod_q, prod_d;
  tag_e                     tag_q, tag_d;
  logic [1:0]               dig_q, dig_d;
  logic [AreaW-1:0]         area_q;
  logic [AccW-1:0]          acc_q;

  logic signed [OpW-1:0]    op;
  logic [FieldW-1:0]        gain;
  logic [StepW-1:0]         base;
  logic [StepW-1:0]         off;
  logic signed [DigitW:0]   digit;
  logic signed [AccW-1:0]   prod_ext;
  logic [AccW-1:0]          prod_sh;
  logic signed [SumW:0]     area;
  logic signed [IntegW:0]   integ_sum;
  logic signed [AccW-25:0]  drive_q58;
  logic                     drive_fits;

  // operand and digit for this step
  always_comb begin
    tag_d = TagNone;
    op    = '0;
    gain  = '0;
    base  = StepArea;
    if (ctrl_i.active) begin
      priority if (ctrl_i.step >= StepArea && ctrl_i.step < StepErr) begin
        tag_d = TagArea;
        op    = OpW'(sum_q);
        gain  = cfg_i.half_period;
        base  = StepArea;
      end else if (ctrl_i.step >= StepErr && ctrl_i.step < StepDiff) begin
        tag_d = TagDrive;
        op    = OpW'(err_q);
        gain  = cfg_i.gain_p;
        base  = StepErr;
      end else if (ctrl_i.step >= StepDiff && ctrl_i.step < StepInteg) begin
        tag_d = TagDrive;
        op    = OpW'(diff_q);
        gain  = cfg_i.gain_d;
        base  = StepDiff;
      end else if (ctrl_i.step >= StepInteg && ctrl_i.step < StepMulEnd) begin
        tag_d = TagDrive;
        op    = integ_q;
        gain  = cfg_i.gain_i;
        base  = StepInteg;
      end else begin
        tag_d = TagNone;
      end
    end
  end

  assign off    = ctrl_i.step - base;
  assign dig_d  = off[1:0];
  assign digit  = (dig_d == 2'd2) ? {op[OpW-1], op[OpW-1 -: DigitW]}
                                  : {1'b0, op[{dig_d, 4'b0000} +: DigitW]};
  assign prod_d = digit * $signed({1'b0, gain});

  assign prod_ext = AccW'(prod_q);
  assign prod_sh  = prod_ext <<< {dig_q, 4'b0000};

  // area is floor(sum * half_period / 2^32)
  assign area      = $signed(area_q[AreaW-1:32]);
  assign integ_sum = (IntegW+1)'(integ_q) + (IntegW+1)'(area);

  always_comb begin
    integ_d = integ_q;
    if (integ_sum[IntegW] != integ_sum[IntegW-1]) begin
      integ_d = integ_sum[IntegW] ? {1'b1, {(IntegW-1){1'b0}}}
                                  : {1'b0, {(IntegW-1){1'b1}}};
    end else begin
      integ_d = integ_sum[IntegW-1:0];
    end
  end

  // floor by 2^24, then saturate to 32 bits
  assign drive_q58  = $signed(acc_q[AccW-1:24]);
  assign drive_fits = (&drive_q58[AccW-25:FieldW-1]) || !(|drive_q58[AccW-25:FieldW-1]);
  assign drive_o    = drive_fits ? drive_q58[FieldW-1:0]
                    : (drive_q58[AccW-25] ? {1'b1, {(FieldW-1){1'b0}}}
                                          : {1'b0, {(FieldW-1){1'b1}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q      <= TagNone;
      last_err_q <= '0;
      integ_q    <= '0;
    end else begin
      tag_q <= tag_d;
      if (ctrl_i.active && ctrl_i.step == StepPrep) begin
        last_err_q <= err_q;
      end
      if (ctrl_i.active && ctrl_i.step == StepIntegUpd) begin
        integ_q <= integ_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    dig_q  <= dig_d;
    if (ctrl_i.start) begin
      err_q <= ErrW'(target_i) - ErrW'(measured_i);
    end
    if (ctrl_i.active && ctrl_i.step == StepPrep) begin
      sum_q  <= SumW'(last_err_q) + SumW'(err_q);
      diff_q <= SumW'(err_q) - SumW'(last_err_q);
      area_q <= '0;
      acc_q  <= '0;
    end else begin
      if (tag_q == TagArea) begin
        area_q <= area_q + prod_sh[AreaW-1:0];
      end
      if (tag_q == TagDrive) begin
        acc_q <= acc_q + prod_sh;
      end
    end
  end

endmodule

// File: rtl/tapc_merge.sv
// Output stage: gathers the lane drives into one result beat, applies the enable.
// Depends on tapc_pkg.
module tapc_merge
  import tapc_pkg::*;
#(
  parameter int unsigned Axes = AxesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic                          enable_i,
  input  logic [Axes-1:0][FieldW-1:0]   drive_i,
  input  logic                          m_ready_i,
  output logic                          m_valid_o,
  output logic [Axes*FieldW-1:0]        m_data_o,
  output logic                          free_o
);

  logic                        valid_q, valid_d;
  logic [Axes-1:0][FieldW-1:0] data_q;

  assign free_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= enable_i ? drive_i : '0;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench for three_axis_pid_controller: streams control ticks over the input bus and
// predicts every drive beat with a local fixed-point PID model kept in step with APB writes.
// Depends on tapc_pkg and the RTL of the block.
module tb_top
  import tapc_pkg::*;
();

  localparam int unsigned NumAxes = 3;
  localparam int unsigned TickW = 2 * NumAxes * FieldW;
  localparam int unsigned DriveW = NumAxes * FieldW;
  localparam int unsigned MaxIdle = 17;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned RegSlots = 2 ** (AddrW - 2);
  localparam int unsigned ItemsPerSetting = 80;
  localparam int unsigned NumSettings = 6;

  localparam logic signed [95:0] IntegHi = 96'sh7FFF_FFFF_FFFF;
  localparam logic signed [95:0] IntegLo = -96'sh8000_0000_0000;
  localparam logic signed [95:0] DriveHi = 96'sh7FFF_FFFF;
  localparam logic signed [95:0] DriveLo = -96'sh8000_0000;

  localparam logic [FieldW-1:0] PosMax = 32'h7FFF_FFFF;
  localparam logic [FieldW-1:0] NegMax = 32'h8000_0000;
  localparam logic [FieldW-1:0] AllOnes = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [FieldW-1:0] gain_p;
    logic [FieldW-1:0] gain_i;
    logic [FieldW-1:0] gain_d;
    logic [FieldW-1:0] half_period;
    logic              enable;
  } pid_setting_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [TickW-1:0]  s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [DriveW-1:0] m_axis_tdata;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  // local copy of the controller registers and per-axis state
  logic [FieldW-1:0]  cur_gain_p;
  logic [FieldW-1:0]  cur_gain_i;
  logic [FieldW-1:0]  cur_gain_d;
  logic [FieldW-1:0]  cur_half_period;
  logic               cur_enable;
  logic signed [32:0] prev_err [NumAxes];
  logic signed [47:0] integ [NumAxes];

  logic [DriveW-1:0] drive_queue [$];
  int unsigned       mismatches = 0;
  int unsigned       cycles = 0;
  bit                tx_quiet = 1'b0;
  bit                rx_quiet = 1'b0;
  string             axis_name [NumAxes] = '{"drive_x", "drive_y", "drive_z"};

  three_axis_pid_controller u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void pid_reset();
    int a;
    cur_gain_p = GainPReset;
    cur_gain_i = GainIReset;
    cur_gain_d = GainDReset;
    cur_half_period = HalfPeriodReset;
    cur_enable = EnableReset;
    for (a = 0; a < NumAxes; a++) begin
      prev_err[a] = '0;
      integ[a] = '0;
    end
  endfunction

  // one control tick: trapezoidal integral, then p, i and d terms floored by 2^24
  function automatic logic [DriveW-1:0] pid_tick(input logic [TickW-1:0] tick);
    logic [DriveW-1:0]        drives;
    logic signed [FieldW-1:0] tgt;
    logic signed [FieldW-1:0] meas;
    logic signed [32:0]       err;
    logic signed [95:0]       hp;
    logic signed [95:0]       gp;
    logic signed [95:0]       gi;
    logic signed [95:0]       gd;
    logic signed [95:0]       ev;
    logic signed [95:0]       dv;
    logic signed [95:0]       sum;
    logic signed [95:0]       acc;
    logic signed [95:0]       tot;
    int                       a;
    drives = '0;
    hp = {64'd0, cur_half_period};
    gp = {64'd0, cur_gain_p};
    gi = {64'd0, cur_gain_i};
    gd = {64'd0, cur_gain_d};
    for (a = 0; a < NumAxes; a++) begin
      tgt = tick[a*FieldW +: FieldW];
      meas = tick[(NumAxes+a)*FieldW +: FieldW];
      err = tgt - meas;
      ev = err;
      dv = ev - prev_err[a];
      sum = prev_err[a];
      sum = sum + ev;
      acc = integ[a];
      acc = acc + ((sum * hp) >>> 32);
      if (acc > IntegHi) acc = IntegHi;
      if (acc < IntegLo) acc = IntegLo;
      tot = (gp * ev + gi * acc + gd * dv) >>> 24;
      if (tot > DriveHi) tot = DriveHi;
      if (tot < DriveLo) tot = DriveLo;
      if (!cur_enable) tot = '0;
      drives[a*FieldW +: FieldW] = tot[FieldW-1:0];
      integ[a] = acc[47:0];
      prev_err[a] = err;
    end
    return drives;
  endfunction

  function automatic logic [TickW-1:0] make_tick(
    input logic [FieldW-1:0] tx, input logic [FieldW-1:0] ty, input logic [FieldW-1:0] tz,
    input logic [FieldW-1:0] mx, input logic [FieldW-1:0] my, input logic [FieldW-1:0] mz);
    return {mz, my, mx, tz, ty, tx};
  endfunction

  function automatic logic [FieldW-1:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6, 7: return $urandom_range(0, 2 ** 21) - 2 ** 20;
      8: return PosMax;
      default: return NegMax;
    endcase
  endfunction

  // measured mostly tracks target closely, as in a running loop
  function automatic logic [TickW-1:0] rand_tick();
    logic [FieldW-1:0] tv [NumAxes];
    logic [FieldW-1:0] mv [NumAxes];
    int                a;
    for (a = 0; a < NumAxes; a++) begin
      tv[a] = rand_value();
      if ($urandom_range(0, 9) < 6) mv[a] = tv[a] + ($urandom_range(0, 2 ** 17) - 2 ** 16);
      else mv[a] = rand_value();
    end
    return make_tick(tv[0], tv[1], tv[2], mv[0], mv[1], mv[2]);
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [DataW-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegGainP: cur_gain_p = value;
      RegGainI: cur_gain_i = value;
      RegGainD: cur_gain_d = value;
      RegHalfPeriod: cur_half_period = value;
      RegEnable: cur_enable = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input pid_setting_t s);
    reg_write(RegGainP, s.gain_p);
    reg_write(RegGainI, s.gain_i);
    reg_write(RegGainD, s.gain_d);
    reg_write(RegHalfPeriod, s.half_period);
    reg_write(RegEnable, {31'd0, s.enable});
  endtask

  task automatic send_tick(input logic [TickW-1:0] tick);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MaxIdle);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= tick;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    drive_queue.push_back(pid_tick(tick));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (drive_queue.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_tick(make_tick('0, '0, '0, '0, '0, '0));
    send_tick(make_tick(PosMax, NegMax, AllOnes, NegMax, PosMax, '0));
    send_tick(make_tick(PosMax, NegMax, AllOnes, NegMax, PosMax, '0));
    send_tick(make_tick(NegMax, PosMax, '0, PosMax, NegMax, AllOnes));
    send_tick(make_tick(PosMax, NegMax, '0, PosMax, NegMax, '0));
    send_tick(make_tick('0, '0, 32'h0001_0001, 32'd1, 32'd3, '0));
    send_tick(make_tick(AllOnes, 32'd5, 32'hFFFE_0000, '0, 32'd7, 32'h0002_0000));
    wait_idle();
    apply_setting('{AllOnes, AllOnes, AllOnes, AllOnes, 1'b1});
    send_tick(make_tick(PosMax, NegMax, 32'd1, NegMax, PosMax, '0));
    send_tick(make_tick(NegMax, PosMax, '0, PosMax, NegMax, 32'd1));
    send_tick(make_tick('0, '0, '0, '0, '0, '0));
    send_tick(make_tick(32'd1, AllOnes, 32'h0000_8000, '0, '0, '0));
    wait_idle();
  endtask

  task automatic test_register_map();
    int i;
    // writes above the last register must leave every register alone
    for (i = int'(RegEnable) + 1; i < RegSlots; i++) reg_write(i[2:0], $urandom());
    send_tick(rand_tick());
    send_tick(rand_tick());
    wait_idle();
  endtask

  task automatic test_enable_off();
    apply_setting('{GainPReset, 32'h0010_0000, GainDReset, HalfPeriodReset, 1'b1});
    // only bit 0 of the enable write counts
    reg_write(RegEnable, 32'hFFFF_FFFE);
    send_tick(make_tick(PosMax, NegMax, 32'h0004_0000, NegMax, PosMax, '0));
    send_tick(rand_tick());
    send_tick(rand_tick());
    wait_idle();
    reg_write(RegEnable, 32'h8000_0003);
    send_tick(make_tick('0, '0, '0, '0, '0, '0));
    send_tick(rand_tick());
    wait_idle();
  endtask

  task automatic test_random_settings();
    pid_setting_t s;
    int           p;
    int           k;
    for (p = 0; p < NumSettings; p++) begin
      case (p)
        0: s = '{GainPReset, GainIReset, GainDReset, HalfPeriodReset, EnableReset};
        1: s = '{AllOnes, AllOnes, AllOnes, AllOnes, 1'b1};
        2: s = '{'0, '0, '0, '0, 1'b1};
        3: s = '{$urandom(), $urandom(), $urandom(), $urandom(), 1'b1};
        4: s = '{$urandom_range(0, 2 ** 26), $urandom_range(0, 2 ** 22),
                 $urandom_range(0, 2 ** 26), $urandom_range(0, 2 ** 24),
                 1'($urandom_range(0, 1))};
        default: s = '{$urandom(), $urandom(), $urandom(), $urandom(), 1'b0};
      endcase
      apply_setting(s);
      for (k = 0; k < ItemsPerSetting; k++) begin
        if (k % 20 == 0) begin
          tx_quiet = ($urandom_range(0, 3) == 0);
          rx_quiet = ($urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 39) == 0) wait_idle();
        send_tick(rand_tick());
      end
      wait_idle();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    m_axis_tready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      int unsigned stall;
      stall = rx_quiet ? 0 : $urandom_range(0, MaxIdle);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  always @(posedge clk_i) begin : drive_check
    logic [DriveW-1:0] want;
    logic [FieldW-1:0] got_f;
    logic [FieldW-1:0] want_f;
    int                a;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (drive_queue.size() == 0) begin
        mismatches++;
        $error("drive beat with no tick pending");
      end else begin
        want = drive_queue.pop_front();
        for (a = 0; a < NumAxes; a++) begin
          got_f = m_axis_tdata[a*FieldW +: FieldW];
          want_f = want[a*FieldW +: FieldW];
          if (got_f !== want_f) begin
            mismatches++;
            $error("%s: expected %0d, got %0d", axis_name[a], $signed(want_f),
                   $signed(got_f));
          end
        end
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pid_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_map();
    test_enable_off();
    test_random_settings();
    wait_idle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tapc_pkg.sv
rtl/tapc_seq.sv
rtl/tapc_lane.sv
rtl/tapc_merge.sv
rtl/three_axis_pid_controller.sv
tb/tb_top.sv
